FILE: sv/bsd_pkg.sv
// Package for the block standard deviation unit.
// Holds shared constants, the back-end state type and the queue status struct.
// No dependencies.
`default_nettype none

package bsd_pkg;

   localparam int BLOCK_LEN_DEFAULT = 16;
   localparam int SAMPLE_W          = 8;
   localparam int RESULT_W          = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   // back-end sequencer, one-hot
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DIV_M = 10'b0000000010,
      ST_REM_M = 10'b0000000100,
      ST_MUL   = 10'b0000001000,
      ST_SUB   = 10'b0000010000,
      ST_DIV_V = 10'b0000100000,
      ST_REM_V = 10'b0001000000,
      ST_FRAC  = 10'b0010000000,
      ST_SQRT  = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

FILE: sv/bsd_front.sv
// Front end of the block standard deviation unit: accepts samples and
// accumulates the block sum and sum of squares. Depends on bsd_pkg.
`default_nettype none

module bsd_front
   import bsd_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT,
   parameter int SUM_W     = $clog2(255 * BLOCK_LEN + 1),
   parameter int SQ_W      = $clog2(65025 * BLOCK_LEN + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire q_status_type        q_status,
   output      logic                q_push,
   output      logic [SUM_W-1:0]    q_sum,
   output      logic [SQ_W-1:0]     q_sq
);

   localparam int CNT_W = $clog2(BLOCK_LEN);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [15:0]       square;
   logic              last;
   logic              accept;

   assign last      = (cnt_ff == CNT_W'(BLOCK_LEN - 1));
   // stall only the closing sample of a block when the queue has no room
   assign req_stall = last && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign square    = 16'(req_sample) * 16'(req_sample);

   assign q_sum  = sum_ff + SUM_W'(req_sample);
   assign q_sq   = sq_ff + SQ_W'(square);
   assign q_push = accept && last;

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      if (accept) begin
         if (last) begin
            cnt_in = '0;
            sum_in = '0;
            sq_in  = '0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            sum_in = q_sum;
            sq_in  = q_sq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/bsd_queue.sv
// Two-entry transaction queue between the front and back ends.
// Depends on bsd_pkg.
`default_nettype none

module bsd_queue
   import bsd_pkg::*;
#(
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output      logic [DATA_W-1:0] pop_data,
   output      q_status_type      status
);

   logic [DATA_W-1:0] data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/bsd_back.sv
// Back end of the block standard deviation unit: reciprocal-multiply division
// by BLOCK_LEN, one multiply, digit-serial square root and the result register.
// Depends on bsd_pkg.
`default_nettype none

module bsd_back
   import bsd_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT,
   parameter int SUM_W     = $clog2(255 * BLOCK_LEN + 1),
   parameter int SQ_W      = $clog2(65025 * BLOCK_LEN + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire q_status_type        q_status,
   input  wire logic [SUM_W-1:0]    q_sum,
   input  wire logic [SQ_W-1:0]     q_sq,
   output      logic                q_pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [RESULT_W-1:0] rsp_std_dev_q8_8
);

   localparam int LOGN   = $clog2(BLOCK_LEN);
   localparam int XW     = (SQ_W > LOGN + 16) ? SQ_W : LOGN + 16;
   localparam int KSH    = XW + LOGN;
   localparam int MW     = XW + 1;
   localparam int PRW    = XW + MW;
   localparam int DIV_W  = SQ_W + 16;
   localparam int RT_W   = (DIV_W + 1) / 2;
   localparam int RAD_W  = 2 * RT_W;
   localparam int PW     = 2 * SUM_W + 1;
   localparam int STEP_W = $clog2(RT_W);
   // ceil(2^KSH / BLOCK_LEN): exact floor division for any dividend below 2^XW
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << KSH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

   back_state_type      state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [XW-1:0]       div_x_ff, div_x_in;
   logic [XW-1:0]       quo_ff, quo_in;
   logic [LOGN-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [RT_W-1:0]     root_ff, root_in;
   logic [RT_W:0]       srem_ff, srem_in;
   logic [RESULT_W-1:0] rsp_ff, rsp_in;

   // divide by BLOCK_LEN
   logic [PRW-1:0]      div_prod;
   logic [XW-1:0]       div_q;
   logic [XW-1:0]       div_back;
   logic [XW-1:0]       rem_full;
   // square root step
   logic [RT_W+2:0]     sq_t;
   logic [RT_W+2:0]     sq_trial;
   logic                sq_ge;
   // deviation sum
   logic [SUM_W:0]      sum_rem;
   logic [PW-1:0]       dev_full;

   assign div_prod = PRW'(div_x_ff) * PRW'(RECIP);
   assign div_q    = XW'(div_prod >> KSH);
   assign div_back = quo_ff * XW'(BLOCK_LEN);
   assign rem_full = div_x_ff - div_back;

   assign sq_t     = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial = (RT_W + 3)'({root_ff, 2'b01});
   assign sq_ge    = (sq_t >= sq_trial);

   assign sum_rem  = (SUM_W + 1)'(sum_ff) + (SUM_W + 1)'(rem_ff);
   assign dev_full = PW'(sq_ff) - prod_ff;

   assign q_pop            = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_std_dev_q8_8 = rsp_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      div_x_in = div_x_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      prod_in  = prod_ff;
      rad_in   = rad_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               sum_in   = q_sum;
               sq_in    = q_sq;
               div_x_in = XW'(q_sum);
               state_in = ST_DIV_M;
            end
         end
         ST_DIV_M: begin
            quo_in   = div_q;
            state_in = ST_REM_M;
         end
         ST_REM_M: begin
            rem_in   = rem_full[LOGN-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // T = Q - m * (S + r), with m the mean and r the remainder
            prod_in  = PW'(quo_ff[SUM_W-1:0]) * PW'(sum_rem);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            div_x_in = XW'(dev_full[SQ_W-1:0]);
            state_in = ST_DIV_V;
         end
         ST_DIV_V: begin
            quo_in   = div_q;
            state_in = ST_REM_V;
         end
         ST_REM_V: begin
            // fraction bits come from the remainder scaled by 2^16
            div_x_in = XW'({rem_full[LOGN-1:0], 16'h0000});
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            rad_in   = RAD_W'({quo_ff[SQ_W-1:0], div_q[15:0]});
            root_in  = '0;
            srem_in  = '0;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            rad_in  = rad_ff << 2;
            step_in = step_ff + STEP_W'(1);
            if (sq_ge) begin
               srem_in = (RT_W + 1)'(sq_t - sq_trial);
               root_in = {root_ff[RT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_t[RT_W:0];
               root_in = {root_ff[RT_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(RT_W - 1)) begin
               // saturate to the result width
               if (root_in > RT_W'(2 ** RESULT_W - 1)) begin
                  rsp_in = '1;
               end else begin
                  rsp_in = root_in[RESULT_W-1:0];
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      div_x_ff <= div_x_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      sum_ff   <= sum_in;
      sq_ff    <= sq_in;
      prod_ff  <= prod_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: sv/block_standard_deviation.sv
// Block standard deviation: one byte sample per cycle into the accumulator, except
// that the closing sample of a block stalls while the queue is full. The back end
// runs divide, remainder, multiply, subtract, divide, remainder and fraction steps,
// the square-root digits and a result state; a two-entry queue parts both ends.
// Synchronous active-high reset clears counts, sums, queue pointers and the sequencer.
`default_nettype none

module block_standard_deviation
   import bsd_pkg::*;
#(
   parameter int BLOCK_LEN = BLOCK_LEN_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [RESULT_W-1:0] rsp_std_dev_q8_8
);

   localparam int SUM_W = $clog2(255 * BLOCK_LEN + 1);
   localparam int SQ_W  = $clog2(65025 * BLOCK_LEN + 1);
   localparam int QW    = SUM_W + SQ_W;

   q_status_type     q_status;
   logic             q_push;
   logic             q_pop;
   logic [SUM_W-1:0] push_sum;
   logic [SQ_W-1:0]  push_sq;
   logic [QW-1:0]    pop_data;

   bsd_front #(
      .BLOCK_LEN(BLOCK_LEN),
      .SUM_W    (SUM_W),
      .SQ_W     (SQ_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_sample(req_sample),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_sum     (push_sum),
      .q_sq      (push_sq)
   );

   bsd_queue #(
      .DATA_W(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({push_sum, push_sq}),
      .pop      (q_pop),
      .pop_data (pop_data),
      .status   (q_status)
   );

   bsd_back #(
      .BLOCK_LEN(BLOCK_LEN),
      .SUM_W    (SUM_W),
      .SQ_W     (SQ_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_sum           (pop_data[QW-1:SQ_W]),
      .q_sq            (pop_data[SQ_W-1:0]),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_std_dev_q8_8(rsp_std_dev_q8_8)
   );

   // never write a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("queue written while full");

   // never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("queue popped while empty");

   // a delivered result is not shown again without a new computation
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated");

   // a block taken by the back end cannot finish in the next cycle
   a_pop_then_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_valid)
      else $error("result too early after pop");

endmodule

`default_nettype wire

FILE: tb/block_standard_deviation_test.sv
// Self-checking testbench for block_standard_deviation: streams byte samples in
// blocks and checks each Q8.8 standard deviation against a local predictor.
// Depends on bsd_pkg and the block_standard_deviation RTL.

module block_standard_deviation_test;
   import bsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLOCK_LEN     = BLOCK_LEN_DEFAULT;
   localparam int RANDOM_BLOCKS = 46;
   localparam int DRAIN_CYCLES  = 100;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int CALM_START    = 600;
   localparam int CALM_END      = 1100;
   localparam int HOLD_START    = 200;
   localparam int HOLD_END      = 500;
   localparam int IDLE_PERCENT  = 7;

   typedef enum int {
      BLK_UNIFORM,
      BLK_CONSTANT,
      BLK_EXTREMES,
      BLK_NARROW
   } block_kind_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [RESULT_W-1:0] rsp_std_dev_q8_8;

   bit [SAMPLE_W-1:0] sample_backlog[$];
   bit [RESULT_W-1:0] expected_std_dev[$];

   // predictor state for the block in progress
   bit [3:0]  acc_count        = '0;
   bit [11:0] acc_sum          = '0;
   bit [19:0] acc_square_sum   = '0;

   bit req_taken      = 1'b0;
   int cycle_count    = 0;
   int error_count    = 0;
   int samples_taken  = 0;
   int results_seen   = 0;
   int max_seen       = 0;

   block_standard_deviation #(
      .BLOCK_LEN(BLOCK_LEN)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_std_dev_q8_8 (rsp_std_dev_q8_8)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic bit [31:0] isqrt64(bit [63:0] value);
      bit [31:0] root;
      bit [31:0] trial;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (32'd1 << i);
         if ({32'd0, trial} * {32'd0, trial} <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // deviation about the truncated mean, scaled by 2^16 before the root to give Q8.8
   function automatic bit [RESULT_W-1:0] std_dev_q8_8_of(bit [11:0] sum, bit [19:0] square_sum);
      bit [63:0] mean;
      bit [63:0] dev_sum;
      bit [63:0] scaled;
      bit [31:0] root;
      mean    = 64'(sum) / 64'(BLOCK_LEN);
      dev_sum = 64'(square_sum) + 64'(BLOCK_LEN) * mean * mean - 64'd2 * mean * 64'(sum);
      scaled  = (dev_sum << 16) / 64'(BLOCK_LEN);
      root    = isqrt64(scaled);
      if (root > 32'hFFFF) begin
         return 16'hFFFF;
      end
      return root[RESULT_W-1:0];
   endfunction

   function automatic bit idle_now();
      if (cycle_count >= CALM_START && cycle_count < CALM_END) begin
         return 1'b0;
      end
      return $urandom_range(99) < IDLE_PERCENT;
   endfunction

   // driver: hold a stalled transaction, otherwise advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (sample_backlog.size() != 0 && !idle_now()) begin
         req_valid  <= 1'b1;
         req_sample <= sample_backlog.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (cycle_count >= HOLD_START && cycle_count < HOLD_END) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_now();
      end
   end

   // monitor: predict on accepted samples, check accepted results
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         samples_taken++;
         if (acc_count == 4'(BLOCK_LEN - 1)) begin
            expected_std_dev.push_back(std_dev_q8_8_of(acc_sum + 12'(req_sample),
                                                       acc_square_sum +
                                                       20'(req_sample) * 20'(req_sample)));
            acc_count      = '0;
            acc_sum        = '0;
            acc_square_sum = '0;
         end else begin
            acc_count      = acc_count + 4'd1;
            acc_sum        = acc_sum + 12'(req_sample);
            acc_square_sum = acc_square_sum + 20'(req_sample) * 20'(req_sample);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_std_dev.size() == 0) begin
            $error("unexpected result: std_dev_q8_8 = %0d", rsp_std_dev_q8_8);
            error_count++;
         end else begin
            if (rsp_std_dev_q8_8 !== expected_std_dev[0]) begin
               $error("std_dev_q8_8 mismatch: expected %0d, actual %0d",
                      expected_std_dev[0], rsp_std_dev_q8_8);
               error_count++;
            end
            if (int'(expected_std_dev[0]) > max_seen) begin
               max_seen = int'(expected_std_dev[0]);
            end
            void'(expected_std_dev.pop_front());
            results_seen++;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      block_kind_type kind;
      bit [SAMPLE_W-1:0] base;

      // directed: alternate the extremes for the widest spread
      for (int i = 0; i < BLOCK_LEN; i++) begin
         sample_backlog.push_back((i % 2) ? 8'hFF : 8'h00);
      end

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         kind = block_kind_type'($urandom_range(3));
         base = 8'($urandom);
         for (int i = 0; i < BLOCK_LEN; i++) begin
            case (kind)
               BLK_UNIFORM: begin
                  sample_backlog.push_back(8'($urandom));
               end
               BLK_CONSTANT: begin
                  sample_backlog.push_back(base);
               end
               BLK_EXTREMES: begin
                  sample_backlog.push_back($urandom_range(1) ? 8'hFF : 8'h00);
               end
               default: begin
                  sample_backlog.push_back((base > 8'd252) ? base - 8'($urandom_range(3))
                                                           : base + 8'($urandom_range(3)));
               end
            endcase
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_backlog.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_std_dev.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_std_dev.size() != 0) begin
         $error("%0d expected results never arrived", expected_std_dev.size());
         error_count++;
      end

      $display("streamed %0d samples in blocks of %0d, checked %0d deviations",
               samples_taken, BLOCK_LEN, results_seen);
      $display("largest deviation seen %0d (Q8.8), %0d mismatches", max_seen, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
